@@ hw/rtl/nrm_pkg.sv @@
// ----------------------------------------------------------------------------
// nrm_pkg
// Shared types and constants for the vector normalisation pipeline.
// ----------------------------------------------------------------------------
package nrm_pkg;

  localparam int unsigned CompW  = 16;
  localparam int unsigned MagW   = 17;
  localparam int unsigned SqW    = 32;
  localparam int unsigned SumW   = 32;
  localparam int unsigned QW     = 15;
  localparam int unsigned WideW  = 68;
  localparam int unsigned Lanes  = 3;
  localparam int unsigned RhsSh  = 30;

  // One component as it moves down the chain of cells.
  typedef struct packed {
    logic                     neg;
    logic signed [WideW-1:0]  rem;
    logic signed [WideW-1:0]  acc;
    logic [QW-1:0]            q;
  } lane_t;

  // One vector in flight.
  typedef struct packed {
    logic                valid;
    logic [SumW-1:0]     s;
    lane_t [Lanes-1:0]   lane;
  } stage_t;

endpackage

@@ hw/rtl/normalize_vector3_core.sv @@
// ----------------------------------------------------------------------------
// normalize_vector3_core
// The pipeline runs through squaring, summing, 15 bit cells and the sign stage.
// Throughput is one vector per cycle; busy never rises and results cannot be
// held off. Each cell decides one bit of all three scale factors at once.
// Reset clears the valid flags and the stage registers of the chain.
// ----------------------------------------------------------------------------
module normalize_vector3_core
  import nrm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CompW-1:0] in_x_i,
  input  logic signed [CompW-1:0] in_y_i,
  input  logic signed [CompW-1:0] in_z_i,
  output logic                    valid_o,
  output logic signed [CompW-1:0] out_x_o,
  output logic signed [CompW-1:0] out_y_o,
  output logic signed [CompW-1:0] out_z_o,
  output logic                    was_zero_o
);

  stage_t                        chain [QW+1];
  logic                          valid_q;
  logic                          zero_q, zero_d;
  logic [Lanes-1:0][CompW-1:0]   res_q, res_d;

  assign busy = 1'b0;

  nrm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .x_i     (in_x_i),
    .y_i     (in_y_i),
    .z_i     (in_z_i),
    .stage_o (chain[0])
  );

  // Cells run from the top result bit down to bit zero.
  for (genvar g = 0; g < QW; g++) begin : g_cell
    nrm_cell #(
      .K (QW - 1 - g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  // A zero vector gives zero outputs and the flag; otherwise apply signs.
  always_comb begin
    zero_d = (chain[QW].s == '0);
    for (int i = 0; i < Lanes; i++) begin
      if (zero_d) begin
        res_d[i] = '0;
      end else if (chain[QW].lane[i].neg) begin
        res_d[i] = CompW'(0) - {1'b0, chain[QW].lane[i].q};
      end else begin
        res_d[i] = {1'b0, chain[QW].lane[i].q};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= chain[QW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    res_q  <= res_d;
  end

  assign valid_o    = valid_q;
  assign out_x_o    = res_q[0];
  assign out_y_o    = res_q[1];
  assign out_z_o    = res_q[2];
  assign was_zero_o = zero_q;

endmodule

@@ hw/rtl/nrm_front.sv @@
// ----------------------------------------------------------------------------
// nrm_front
// Squares the components, sums them and seeds the search for each lane.
// ----------------------------------------------------------------------------
module nrm_front
  import nrm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [CompW-1:0] x_i,
  input  logic signed [CompW-1:0] y_i,
  input  logic signed [CompW-1:0] z_i,
  output stage_t                  stage_o
);

  logic                            v1_q;
  logic [Lanes-1:0]                neg_q;
  logic [Lanes-1:0][SqW-1:0]       sq_q, sq_d;
  logic [Lanes-1:0][MagW-1:0]      mag;
  logic [Lanes-1:0][CompW-1:0]     comp;
  logic [SumW-1:0]                 sum;
  stage_t                          st_d, st_q;

  assign comp[0] = x_i;
  assign comp[1] = y_i;
  assign comp[2] = z_i;

  // Magnitudes and squares of the raw components.
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      mag[i]  = comp[i][CompW-1] ? (MagW'(0) - {1'b1, comp[i]}) : {1'b0, comp[i]};
      sq_d[i] = SqW'(mag[i]) * SqW'(mag[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
    for (int i = 0; i < Lanes; i++) begin
      neg_q[i] <= comp[i][CompW-1];
    end
  end

  // Squared length and the starting remainder rhs - s with acc = -s.
  always_comb begin
    sum = sq_q[0] + sq_q[1] + sq_q[2];
    st_d.valid = v1_q;
    st_d.s     = sum;
    for (int i = 0; i < Lanes; i++) begin
      st_d.lane[i].neg = neg_q[i];
      st_d.lane[i].rem = ($signed(WideW'(sq_q[i])) <<< RhsSh) - $signed(WideW'(sum));
      st_d.lane[i].acc = -$signed(WideW'(sum));
      st_d.lane[i].q   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign stage_o = st_q;

endmodule

@@ hw/rtl/nrm_cell.sv @@
// ----------------------------------------------------------------------------
// nrm_cell
// Decides one result bit per lane by trial subtraction of the growth term.
// ----------------------------------------------------------------------------
module nrm_cell
  import nrm_pkg::*;
#(
  parameter int unsigned K = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stage_t stage_i,
  output stage_t stage_o
);

  stage_t                               st_d, st_q;
  logic [Lanes-1:0][WideW-1:0]          diff;
  logic [Lanes-1:0][WideW-1:0]          grow;
  logic signed [WideW-1:0]              s_w;

  // Setting bit K grows (2q-1)^2*s by acc*2^(K+2) + s*2^(2K+2).
  always_comb begin
    s_w  = $signed(WideW'(stage_i.s));
    st_d = stage_i;
    for (int i = 0; i < Lanes; i++) begin
      grow[i] = (stage_i.lane[i].acc <<< (K + 2)) + (s_w <<< (2 * K + 2));
      diff[i] = stage_i.lane[i].rem - $signed(grow[i]);
      if (!diff[i][WideW-1]) begin
        st_d.lane[i].rem  = $signed(diff[i]);
        st_d.lane[i].acc  = stage_i.lane[i].acc + (s_w <<< (K + 1));
        st_d.lane[i].q[K] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign stage_o = st_q;

endmodule
